// ----- src/msjb_pkg.sv -----
// Package for the multi-sender jitter buffer: sizes, field types and the
// work-queue entry that links the front end to the back end. No dependencies.
package msjb_pkg;

   localparam int SPEAKERS      = 4;
   localparam int FRAME_SAMPLES = 160;
   localparam int RING_FRAMES   = 8;
   localparam int RING_CAP      = RING_FRAMES * FRAME_SAMPLES;
   localparam int SLOT_W        = 2;
   localparam int PTR_W         = $clog2(RING_CAP);
   localparam int CNT_W         = 11;
   localparam int ADDR_W        = $clog2(SPEAKERS * RING_CAP);
   localparam int FS_W          = $clog2(FRAME_SAMPLES + 1);
   localparam int QDEPTH        = 2;

   localparam logic [31:0] STALE_START = 32'hFFFF_FFFF;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [31:0]        sender_id;
      logic [15:0]        seq_number;
      logic signed [15:0] sample_in;
      logic               frame_start;
      logic [1:0]         slot_select;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               valid_res;
      logic [1:0]         slot_used;
      logic [10:0]        fill_level;
   } rsp_type;

   // Work word handed from front end to back end.
   typedef struct packed {
      op_type             operation;
      logic [SLOT_W-1:0]  slot;
      logic               frame_start;
      logic               claimed;
      logic [15:0]        seq_number;
      logic signed [15:0] sample_in;
   } work_type;

   function automatic logic [PTR_W-1:0] ring_wrap(input logic [PTR_W:0] v);
      ring_wrap = (v >= (PTR_W+1)'(RING_CAP)) ? PTR_W'(v - (PTR_W+1)'(RING_CAP))
                                              : v[PTR_W-1:0];
   endfunction

endpackage

// ----- src/msjb_if.sv -----
// Valid/ready channel interface for request and response words.
// Depends on msjb_pkg.
interface msjb_req_if import msjb_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface msjb_rsp_if import msjb_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- src/msjb_front.sv -----
// Front end: accepts request words, resolves the sender slot on frame start.
// Depends on msjb_pkg.
module msjb_front import msjb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     wq_valid,
   input  logic     wq_ready,
   output work_type wq_data
);
   logic [SPEAKERS-1:0] in_use_ff, in_use_in;
   logic [31:0]         sender_ff [SPEAKERS];
   logic [31:0]         active_ff [SPEAKERS];
   logic                hit;
   logic [SLOT_W-1:0]   hit_at, free_at, stale_at, pick;
   logic                free_any;
   logic [31:0]         stale_ms;

   always_comb begin
      hit = 1'b0; hit_at = '0; free_any = 1'b0; free_at = '0;
      stale_at = '0; stale_ms = STALE_START;
      for (int i = SPEAKERS-1; i >= 0; i--) begin
         if (in_use_ff[i] && sender_ff[i] == in_data.sender_id) begin
            hit = 1'b1; hit_at = SLOT_W'(i);
         end
         if (!in_use_ff[i]) begin
            free_any = 1'b1; free_at = SLOT_W'(i);
         end
      end
      for (int i = 0; i < SPEAKERS; i++) begin
         if (in_use_ff[i] && active_ff[i] < stale_ms) begin
            stale_ms = active_ff[i]; stale_at = SLOT_W'(i);
         end
      end
      pick = hit ? hit_at : (free_any ? free_at : stale_at);
   end

   assign in_ready = wq_ready;
   assign wq_valid = in_valid;

   always_comb begin
      wq_data.operation   = in_data.operation;
      wq_data.slot        = (in_data.operation == OP_POP) ? in_data.slot_select : pick;
      wq_data.frame_start = (in_data.operation == OP_PUSH) && in_data.frame_start;
      wq_data.claimed     = !hit;
      wq_data.seq_number  = in_data.seq_number;
      wq_data.sample_in   = in_data.sample_in;
   end

   always_comb begin
      in_use_in = in_use_ff;
      if (in_valid && wq_ready && wq_data.frame_start) in_use_in[pick] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         for (int i = 0; i < SPEAKERS; i++) begin
            sender_ff[i] <= '0; active_ff[i] <= '0;
         end
      end else begin
         in_use_ff <= in_use_in;
         if (in_valid && wq_ready && wq_data.frame_start) begin
            sender_ff[pick] <= in_data.sender_id;
            active_ff[pick] <= in_data.now_ms;
         end
      end
   end
endmodule

// ----- src/msjb_queue.sv -----
// Short work queue between front end and back end.
// Depends on msjb_pkg.
module msjb_queue import msjb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  work_type wr_data,
   output logic     rd_valid,
   input  logic     rd_ready,
   output work_type rd_data
);
   localparam int QP_W = $clog2(QDEPTH);
   work_type          mem_ff [QDEPTH];
   logic [QP_W-1:0]   wp_ff, rp_ff;
   logic [QP_W:0]     cnt_ff;
   logic              push, pop;

   assign wr_ready = cnt_ff != (QP_W+1)'(QDEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QP_W+1)'(push) - (QP_W+1)'(pop);
      end
   end
endmodule

// ----- src/msjb_back.sv -----
// Back end: sequence check, gap fill, ring update and sample memory.
// Depends on msjb_pkg.
module msjb_back import msjb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wq_valid,
   output logic     wq_ready,
   input  work_type wq_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_FILL = 5'b00010,
      ST_APND = 5'b00100,
      ST_READ = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  head_ff [SPEAKERS];
   logic [CNT_W-1:0]  count_ff [SPEAKERS];
   logic [15:0]       exp_ff [SPEAKERS];
   logic [SPEAKERS-1:0] have_ff, used_ff;
   logic              accept_ff;
   logic [SLOT_W-1:0] cur_ff;
   work_type          job_ff;
   logic [15:0]       gap_ff;
   logic [FS_W-1:0]   fcnt_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic signed [15:0] mem [SPEAKERS * RING_CAP];
   logic [ADDR_W-1:0] waddr, raddr;
   logic              wen;
   logic signed [15:0] wdata, rdata_ff;

   // Shorthands for the job slot: a pop names its slot, a push goes to the current one.
   logic [SLOT_W-1:0] s;
   logic [CNT_W-1:0]  cnt_s;
   logic [PTR_W-1:0]  head_s;
   logic              fits;
   logic [15:0]       delta;
   logic              fill_first, fill_wr;

   assign s      = (job_ff.operation == OP_POP) ? job_ff.slot : cur_ff;
   assign cnt_s  = count_ff[s];
   assign head_s = head_ff[s];
   assign fits   = ({1'b0, cnt_s} + (CNT_W+1)'(FRAME_SAMPLES)) <= (CNT_W+1)'(RING_CAP);
   assign delta  = job_ff.seq_number - exp_ff[s];

   // Check room once per silent frame, then write the whole frame.
   assign fill_first = (fcnt_ff == '0) && (gap_ff == '0);
   assign fill_wr    = (gap_ff != '0) && ((fcnt_ff != '0) || fits);

   assign wq_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] sl,
                                                 input logic [PTR_W-1:0] p);
      addr_of = ADDR_W'(sl) * ADDR_W'(RING_CAP) + ADDR_W'(p);
   endfunction

   logic [PTR_W-1:0] tail;
   assign tail  = ring_wrap({1'b0, head_s} + (PTR_W+1)'(cnt_s));
   assign waddr = addr_of(s, tail);
   assign raddr = addr_of(s, head_s);

   always_comb begin
      wen = 1'b0; wdata = job_ff.sample_in;
      if (state_ff == ST_FILL && fill_wr) begin
         wen = 1'b1; wdata = '0;
      end
      if (state_ff == ST_APND && accept_ff
          && cnt_s < CNT_W'(RING_CAP)) wen = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (wq_valid && wq_ready)
            state_in = (wq_data.operation == OP_POP) ? ST_READ
                     : (wq_data.frame_start ? ST_FILL : ST_APND);
         ST_FILL: if (fill_first) begin
            if (have_ff[s] && !delta[15] && delta != '0) state_in = ST_FILL;
            else state_in = ST_APND;
         end else if (!fill_wr) state_in = ST_APND;
         ST_APND: state_in = ST_IDLE;
         ST_READ: state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rsp_valid_ff <= 1'b0; accept_ff <= 1'b0;
         cur_ff <= '0; have_ff <= '0; used_ff <= '0;
         gap_ff <= '0; fcnt_ff <= '0;
         for (int i = 0; i < SPEAKERS; i++) begin
            head_ff[i] <= '0; count_ff[i] <= '0; exp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (out_valid && out_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (wq_valid && wq_ready) begin
               job_ff <= wq_data;
               if (wq_data.frame_start) begin
                  cur_ff <= wq_data.slot;
                  used_ff[wq_data.slot] <= 1'b1;
                  if (wq_data.claimed) begin
                     head_ff[wq_data.slot]  <= '0;
                     count_ff[wq_data.slot] <= '0;
                     exp_ff[wq_data.slot]   <= '0;
                     have_ff[wq_data.slot]  <= 1'b0;
                  end
                  gap_ff <= '0; fcnt_ff <= '0;
               end
            end
            ST_FILL: begin
               // first cycle computes the gap; later ones write silence, then close the frame
               if (fill_first) begin
                  if (have_ff[s] && delta[15]) begin
                     accept_ff <= 1'b0;
                  end else begin
                     accept_ff <= 1'b1;
                     if (have_ff[s] && delta != '0) begin
                        gap_ff   <= delta;
                     end else begin
                        if (!fits) begin
                           head_ff[s]  <= ring_wrap({1'b0, head_s}
                                          + (PTR_W+1)'(FRAME_SAMPLES));
                           count_ff[s] <= cnt_s - CNT_W'(FRAME_SAMPLES);
                        end
                        exp_ff[s] <= job_ff.seq_number + 16'd1;
                        have_ff[s] <= 1'b1;
                     end
                  end
               end else if (fill_wr) begin
                  count_ff[s] <= cnt_s + 1'b1;
                  if (fcnt_ff == FS_W'(FRAME_SAMPLES - 1)) begin
                     fcnt_ff <= '0;
                     gap_ff  <= gap_ff - 16'd1;
                     if (gap_ff == 16'd1) begin
                        // gap done: finish frame bookkeeping
                        gap_ff <= '0; fcnt_ff <= FS_W'(1);
                     end
                  end else fcnt_ff <= fcnt_ff + 1'b1;
               end else begin
                  if (!fits) begin
                     head_ff[s]  <= ring_wrap({1'b0, head_s} + (PTR_W+1)'(FRAME_SAMPLES));
                     count_ff[s] <= cnt_s - CNT_W'(FRAME_SAMPLES);
                  end
                  exp_ff[s] <= job_ff.seq_number + 16'd1;
                  have_ff[s] <= 1'b1;
                  gap_ff <= '0; fcnt_ff <= '0;
               end
            end
            ST_APND: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.sample_out <= '0;
               rsp_ff.slot_used  <= cur_ff;
               if (wen) begin
                  count_ff[cur_ff] <= count_ff[cur_ff] + 1'b1;
                  rsp_ff.valid_res  <= 1'b1;
                  rsp_ff.fill_level <= count_ff[cur_ff] + 1'b1;
               end else begin
                  rsp_ff.valid_res  <= 1'b0;
                  rsp_ff.fill_level <= count_ff[cur_ff];
               end
            end
            ST_READ: ;
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.slot_used <= s;
               if (used_ff[s] && cnt_s != '0) begin
                  rsp_ff.sample_out <= rdata_ff;
                  rsp_ff.valid_res  <= 1'b1;
                  rsp_ff.fill_level <= cnt_s - 1'b1;
                  head_ff[s]  <= ring_wrap({1'b0, head_s} + (PTR_W+1)'(1));
                  count_ff[s] <= cnt_s - 1'b1;
               end else begin
                  rsp_ff.sample_out <= '0;
                  rsp_ff.valid_res  <= 1'b0;
                  rsp_ff.fill_level <= cnt_s;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- src/multi_sender_jitter_buffer.sv -----
// Top level of the multi-sender jitter buffer.
// Depends on msjb_pkg, msjb_if, msjb_front, msjb_queue and msjb_back.
//
// Four speaker slots, each a ring of 1280 samples in one shared sample
// memory. The front end takes a request word per cycle while the queue has
// room, resolves the slot on frame start (hit, lowest free, or least recently
// active) and queues the word. The back end handles one word at a time: a
// push ends in the append state, a pop uses the read and output states; a
// frame start checks the sequence, writes silent gap frames (one memory write
// per cycle) and closes the gap in the fill state. One response word per
// request; the back end takes no new word until the response is accepted.
module multi_sender_jitter_buffer import msjb_pkg::*; (
   input logic       clock,
   input logic       reset,
   msjb_req_if.sink  req,
   msjb_rsp_if.source rsp
);
   logic     wq_valid, wq_ready, bq_valid, bq_ready;
   work_type wq_data, bq_data;

   // classify and claim slots
   msjb_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_data (req.data),
      .wq_valid, .wq_ready, .wq_data
   );

   // decouple the two halves
   msjb_queue u_queue (
      .clock, .reset,
      .wr_valid (wq_valid), .wr_ready (wq_ready), .wr_data (wq_data),
      .rd_valid (bq_valid), .rd_ready (bq_ready), .rd_data (bq_data)
   );

   // ring update and response
   msjb_back u_back (
      .clock, .reset,
      .wq_valid (bq_valid), .wq_ready (bq_ready), .wq_data (bq_data),
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_data (rsp.data)
   );
endmodule

// ----- test/tb_multi_sender_jitter_buffer.sv -----
// Testbench for the multi-sender jitter buffer: drives push and pop words on the
// request channel and checks every response against an internal predictor.
// Depends on msjb_pkg, msjb_if and the multi_sender_jitter_buffer RTL.
module tb_multi_sender_jitter_buffer;
   import msjb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   msjb_req_if req_ch ();
   msjb_rsp_if rsp_ch ();

   multi_sender_jitter_buffer DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // Predictor state: a copy of the per-slot ring bookkeeping.
   logic              slot_busy   [SPEAKERS];
   logic [31:0]       slot_owner  [SPEAKERS];
   logic [31:0]       slot_seen_ms[SPEAKERS];
   logic [15:0]       ring_mem    [SPEAKERS][RING_CAP];
   int unsigned       ring_rd     [SPEAKERS];
   int unsigned       ring_fill   [SPEAKERS];
   logic [15:0]       next_seq    [SPEAKERS];
   logic              seq_known   [SPEAKERS];
   logic              taking_frame;
   int unsigned       active_slot;

   rsp_type           expected_rsps[$];
   int                error_count = 0;
   int                rsp_count = 0;
   int                push_stored;
   int                pop_hits;
   int                drops_seen;
   int                hold_off;      // long receiver stall, in cycles
   int                hold_asks;     // hold-offs asked for by the tests
   int                hold_done;     // hold-offs started by the receiver

   // Per-sender sequence bookkeeping for the random part.
   logic [31:0]       talker_id [8];
   logic [15:0]       talker_seq[8];
   int unsigned       talker_ms;

   task automatic report(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, what);
   endtask

   function automatic void predictor_reset();
      for (int i = 0; i < SPEAKERS; i++) begin
         slot_busy[i] = 1'b0;
         slot_owner[i] = '0;
         slot_seen_ms[i] = '0;
         ring_rd[i] = 0;
         ring_fill[i] = 0;
         next_seq[i] = '0;
         seq_known[i] = 1'b0;
      end
      taking_frame = 1'b0;
      active_slot = 0;
   endfunction

   function automatic bit ring_put(int unsigned s, logic [15:0] v);
      if (ring_fill[s] >= RING_CAP) return 1'b0;
      ring_mem[s][(ring_rd[s] + ring_fill[s]) % RING_CAP] = v;
      ring_fill[s]++;
      return 1'b1;
   endfunction

   // Find the sender's slot or claim a free or the stalest one.
   function automatic int unsigned find_slot(logic [31:0] who, logic [31:0] now);
      int unsigned free_at, stale_at, pick;
      logic [31:0] stale_ms;
      free_at = SPEAKERS;
      stale_at = 0;
      stale_ms = STALE_START;
      for (int i = 0; i < SPEAKERS; i++) begin
         if (slot_busy[i] && slot_owner[i] == who) begin
            slot_seen_ms[i] = now;
            return i;
         end
      end
      for (int i = 0; i < SPEAKERS; i++) begin
         if (!slot_busy[i]) begin
            if (free_at == SPEAKERS) free_at = i;
         end else if (slot_seen_ms[i] < stale_ms) begin
            stale_ms = slot_seen_ms[i];
            stale_at = i;
         end
      end
      pick = (free_at < SPEAKERS) ? free_at : stale_at;
      slot_busy[pick] = 1'b1;
      slot_owner[pick] = who;
      slot_seen_ms[pick] = now;
      ring_rd[pick] = 0;
      ring_fill[pick] = 0;
      next_seq[pick] = '0;
      seq_known[pick] = 1'b0;
      return pick;
   endfunction

   // Sequence check, gap fill and overflow on a frame start.
   function automatic bit open_frame(int unsigned s, logic [15:0] seq);
      logic [15:0] delta;
      bit ok;
      if (seq_known[s]) begin
         delta = seq - next_seq[s];
         if (delta[15]) return 1'b0;
         while (delta > 0 && ring_fill[s] + FRAME_SAMPLES <= RING_CAP) begin
            for (int k = 0; k < FRAME_SAMPLES; k++) ok = ring_put(s, 16'h0000);
            next_seq[s] = next_seq[s] + 16'd1;
            delta--;
         end
      end
      if (ring_fill[s] + FRAME_SAMPLES > RING_CAP) begin
         ring_rd[s] = (ring_rd[s] + FRAME_SAMPLES) % RING_CAP;
         ring_fill[s] -= FRAME_SAMPLES;
      end
      next_seq[s] = seq + 16'd1;
      seq_known[s] = 1'b1;
      return 1'b1;
   endfunction

   function automatic rsp_type predict_buffer(req_type w);
      rsp_type r;
      int unsigned s;
      r = '0;
      if (w.operation == OP_PUSH) begin
         if (w.frame_start) begin
            active_slot = find_slot(w.sender_id, w.now_ms);
            taking_frame = open_frame(active_slot, w.seq_number);
            if (!taking_frame) drops_seen++;
         end
         if (taking_frame && ring_put(active_slot, w.sample_in)) begin
            r.valid_res = 1'b1;
            push_stored++;
         end
         r.slot_used = active_slot[1:0];
         r.fill_level = ring_fill[active_slot][10:0];
      end else begin
         s = w.slot_select;
         r.slot_used = w.slot_select;
         if (slot_busy[s] && ring_fill[s] > 0) begin
            r.sample_out = ring_mem[s][ring_rd[s]];
            ring_rd[s] = (ring_rd[s] + 1) % RING_CAP;
            ring_fill[s]--;
            r.valid_res = 1'b1;
            pop_hits++;
         end
         r.fill_level = ring_fill[s][10:0];
      end
      return r;
   endfunction

   // Send one word; predict it at the accepting edge. Words come in bursts, often with idle gaps between.
   int burst_left;
   task automatic send_word(input req_type w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      do @(posedge clock); while (!req_ch.ready);
      expected_rsps.push_back(predict_buffer(w));
   endtask

   function automatic req_type push_word(logic [31:0] who, logic [15:0] seq,
                                         logic [15:0] pcm, logic start,
                                         logic [31:0] now);
      req_type w;
      w = '0;
      w.operation = OP_PUSH;
      w.sender_id = who;
      w.seq_number = seq;
      w.sample_in = pcm;
      w.frame_start = start;
      w.now_ms = now;
      w.slot_select = 2'($urandom_range(0, 3));
      return w;
   endfunction

   function automatic req_type pop_word(logic [1:0] s);
      req_type w;
      w = '0;
      w.operation = OP_POP;
      w.slot_select = s;
      w.sender_id = $urandom;
      w.seq_number = 16'($urandom);
      w.sample_in = 16'($urandom);
      w.frame_start = 1'($urandom_range(0, 1));
      w.now_ms = $urandom;
      return w;
   endfunction

   // Receiver: stall on its own pattern; long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_off <= 0;
         hold_done <= 0;
      end else if (hold_done != hold_asks) begin
         hold_done <= hold_asks;
         hold_off <= 300;
         rsp_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         case ((rsp_count / 64) % 3)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   // Check each accepted response against the oldest expectation.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            report($sformatf("unexpected response %p", got));
         end else begin
            want = expected_rsps.pop_front();
            if (got.sample_out !== want.sample_out)
               report($sformatf("sample_out %h, want %h", got.sample_out, want.sample_out));
            if (got.valid_res !== want.valid_res)
               report($sformatf("valid_res %b, want %b", got.valid_res, want.valid_res));
            if (got.slot_used !== want.slot_used)
               report($sformatf("slot_used %0d, want %0d", got.slot_used, want.slot_used));
            if (got.fill_level !== want.fill_level)
               report($sformatf("fill_level %0d, want %0d", got.fill_level, want.fill_level));
         end
      end
   end

   // Push a frame of n samples; samples after the first carry junk headers.
   task automatic push_frame(logic [31:0] who, logic [15:0] seq, logic [31:0] now,
                             int n);
      for (int k = 0; k < n; k++)
         send_word(push_word(k == 0 ? who : $urandom, k == 0 ? seq : 16'($urandom),
                             16'($urandom), k == 0, now));
   endtask

   // Directed: field extremes, both operations, pops of empty and unused slots.
   task automatic test_directed();
      send_word(pop_word(2'd0));
      send_word(pop_word(2'd3));
      send_word(push_word(32'h0, 16'h0, 16'h0, 1'b0, 32'h0));       // ignored mid-frame
      send_word(push_word(32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 1'b1, 32'hFFFF_FFFF));
      send_word(push_word(32'h0, 16'h0, 16'h7FFF, 1'b0, 32'h0));
      send_word(push_word(32'h0, 16'h0, 16'hFFFF, 1'b1, 32'h0));
      send_word(push_word(32'h0, 16'h0, 16'h1234, 1'b1, 32'h5));   // duplicate: drop
      send_word(push_word(32'h0, 16'h0, 16'h1111, 1'b0, 32'h5));   // dropped frame body
      send_word(push_word(32'h0, 16'h3, 16'h4321, 1'b1, 32'h6));   // gap of two frames
      send_word(pop_word(2'd0));
      send_word(pop_word(2'd1));
      send_word(pop_word(2'd1));
      send_word(push_word(32'hFFFF_FFFF, 16'h8000, 16'h5555, 1'b1, 32'h7)); // seen as late: drop
      send_word(pop_word(2'd0));
      send_word(push_word(32'h2, 16'h9, 16'h0001, 1'b1, 32'h8));
      send_word(push_word(32'h3, 16'h9, 16'h0002, 1'b1, 32'h9));
      send_word(push_word(32'h4, 16'h9, 16'h0003, 1'b1, 32'h3));   // evict stalest
      send_word(push_word(32'h5, 16'h9, 16'h0004, 1'b1, 32'h1));
      send_word(pop_word(2'd2));
      send_word(pop_word(2'd3));
   endtask

   // Overflow: a seven-frame gap nearly fills the ring; a long frame drops the oldest
   // frame, tops the ring off and runs past capacity; the next frame drops one more.
   task automatic test_ring_full();
      push_frame(32'h77, 16'h0, 32'h100, 1);
      push_frame(32'h77, 16'h8, 32'h101, 323);
      push_frame(32'h77, 16'h9, 32'h102, 3);
      repeat (4) send_word(pop_word(2'($urandom_range(0, 3))));
   endtask

   // Receiver holds off while the sender keeps offering words.
   task automatic test_backpressure();
      hold_asks++;
      push_frame(32'h99, 16'h0, 32'h200, 40);
   endtask

   // Random: mostly well-formed frames from a few talkers, with pops and noise.
   task automatic test_random(int n);
      int sent, t, len;
      for (int i = 0; i < 8; i++) begin
         talker_id[i] = (i == 7) ? $urandom : i * 32'h1111_0000 + 5;
         talker_seq[i] = 16'($urandom);
      end
      sent = 0;
      while (sent < n) begin
         talker_ms += $urandom_range(0, 40);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               t = $urandom_range(0, 5);
               case ($urandom_range(0, 7))
                  0: talker_seq[t] -= 16'($urandom_range(1, 3));     // late
                  1: talker_seq[t] += 16'($urandom_range(1, 4));     // gap
                  2: talker_seq[t] = 16'($urandom);                  // wild
                  default: ;
               endcase
               len = $urandom_range(1, 12);
               push_frame(talker_id[t], talker_seq[t], talker_ms, len);
               talker_seq[t]++;
               sent += len;
            end
            5, 6, 7, 8: begin
               len = $urandom_range(1, 10);
               for (int k = 0; k < len; k++)
                  send_word(pop_word(2'($urandom_range(0, 3))));
               sent += len;
            end
            default: begin
               send_word(push_word($urandom, 16'($urandom), 16'($urandom),
                                   1'($urandom_range(0, 1)), $urandom));
               sent++;
            end
         endcase
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      hold_asks = 0;
      burst_left = 0;
      push_stored = 0;
      pop_hits = 0;
      drops_seen = 0;
      talker_ms = 0;
      predictor_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_ring_full();
      test_backpressure();
      test_random(600);
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d responses: %0d samples stored, %0d samples popped,",
               rsp_count, push_stored, pop_hits);
      $display("%0d frames dropped as late or duplicate.", drops_seen);
      if (error_count == 0)
         $display("multi_sender_jitter_buffer: match");
      else
         $display("multi_sender_jitter_buffer: mismatch");
      $finish;
   end

   // Upper bound: gap fills of up to eight silent frames dominate.
   initial begin
      #40000000;
      $display("multi_sender_jitter_buffer: mismatch");
      $finish;
   end

endmodule
